@@ design/bdc_pkg.sv @@
// Shared types for the button debouncer with click and long-press detection.
`timescale 1ns / 1ps

package bdc_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned CFG_W  = 16;

  // Register indexes on the configuration port
  localparam logic REG_DEBOUNCE_TIME   = 1'b0;
  localparam logic REG_LONG_PRESS_TIME = 1'b1;

  localparam logic [CFG_W-1:0] DEBOUNCE_TIME_RST   = 16'd30;
  localparam logic [CFG_W-1:0] LONG_PRESS_TIME_RST = 16'd600;

  // Sample kinds carried in tuser
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_RESYNC = 1'b1;

  typedef struct packed {
    logic              func;
    logic              raw_down;
    logic [TIME_W-1:0] now_ms;
  } item_t;

  typedef struct packed {
    logic              raw_level;
    logic              stable_level;
    logic              long_fired;
    logic [TIME_W-1:0] raw_change_time;
    logic [TIME_W-1:0] press_start_time;
  } state_t;

  typedef struct packed {
    logic [TIME_W-1:0] hold_ms;
    logic              down_level;
    logic              long_press_event;
    logic              click_event;
    logic              release_event;
    logic              press_event;
  } result_t;

  localparam state_t STATE_RST = '{
    raw_level:        1'b0,
    stable_level:     1'b0,
    long_fired:       1'b0,
    raw_change_time:  '0,
    press_start_time: '0
  };

endpackage

@@ design/bdc_core.sv @@
// Next-state and result logic for one button sample.
`timescale 1ns / 1ps

module bdc_core (
  input  bdc_pkg::item_t                 item,
  input  bdc_pkg::state_t                state,
  input  logic [bdc_pkg::CFG_W-1:0]      debounce_time,
  input  logic [bdc_pkg::CFG_W-1:0]      long_press_time,
  output bdc_pkg::state_t                state_next,
  output bdc_pkg::result_t               result
);

  logic                        resync;
  logic                        raw_changed;
  logic [bdc_pkg::TIME_W-1:0]  change_time;
  logic [bdc_pkg::TIME_W-1:0]  settled_ms;
  logic [bdc_pkg::TIME_W-1:0]  held_ms;
  logic                        take;
  logic                        press;
  logic                        release_ev;
  logic                        stable_new;
  logic                        fired_mid;
  logic [bdc_pkg::TIME_W-1:0]  hold;
  logic                        long_ev;

  always_comb begin
    resync      = (item.func == bdc_pkg::FUNC_RESYNC);
    raw_changed = (item.raw_down != state.raw_level);
    change_time = (resync || raw_changed) ? item.now_ms : state.raw_change_time;

    // settle check; a change in this sample gives zero elapsed time
    settled_ms = item.now_ms - change_time;
    take = !resync && (settled_ms >= {{(bdc_pkg::TIME_W-bdc_pkg::CFG_W){1'b0}}, debounce_time})
           && (state.stable_level != item.raw_down);

    press      = take && item.raw_down;
    release_ev = take && !item.raw_down;
    stable_new = (resync || take) ? item.raw_down : state.stable_level;
    fired_mid  = press ? 1'b0 : state.long_fired;

    // a fresh press restarts the hold at zero
    held_ms = item.now_ms - state.press_start_time;
    hold    = (!resync && stable_new && !press) ? held_ms : '0;
    long_ev = !resync && stable_new && !fired_mid
              && (hold >= {{(bdc_pkg::TIME_W-bdc_pkg::CFG_W){1'b0}}, long_press_time});

    state_next.raw_level        = item.raw_down;
    state_next.stable_level     = stable_new;
    state_next.long_fired       = resync ? 1'b0 : (fired_mid || long_ev);
    state_next.raw_change_time  = change_time;
    state_next.press_start_time = (resync || press) ? item.now_ms : state.press_start_time;

    result.press_event      = press;
    result.release_event    = release_ev;
    result.click_event      = release_ev && !state.long_fired;
    result.long_press_event = long_ev;
    result.down_level       = stable_new;
    result.hold_ms          = hold;
  end

endmodule

@@ design/button_debounce_click_longpress.sv @@
// Top level: button debouncer with press, release, click and long-press events.
`timescale 1ns / 1ps

// Takes one button sample per transaction on the s_ side (raw level plus a
// free-running ms timestamp, or a resync in tuser) and returns exactly one
// result transaction on the m_ side. Throughput is one transaction per clock
// while m_tready does not stall it; an item passes the input register, then
// the result register. The single update of the debouncer state per clock,
// done as the item moves from the input register to the result register, sets
// that rate. All timestamps are compared as wrapped 32-bit differences. The
// user must write the thresholds through cfg_we/cfg_index/cfg_data only while
// no transaction is in flight, which is not enforced; they reset to 30 ms and 600 ms.

module button_debounce_click_longpress (
  input  logic                       clk,
  input  logic                       rst,
  // slave side
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [39:0]                s_tdata,   // raw_down[0], now_ms[32:1], zero pad
  input  logic                       s_tuser,   // func
  // master side
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [39:0]                m_tdata,   // press_event[0], release_event[1],
                                                // click_event[2], long_press_event[3],
                                                // down_level[4], hold_ms[36:5], zero pad
  // configuration writes
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [bdc_pkg::CFG_W-1:0]  cfg_data
);

  logic [bdc_pkg::CFG_W-1:0] debounce_time;
  logic [bdc_pkg::CFG_W-1:0] long_press_time;

  // input register stage
  logic                      in_valid;
  bdc_pkg::item_t            in_item;

  // debouncer state and result register
  bdc_pkg::state_t           state;
  bdc_pkg::state_t           state_next;
  bdc_pkg::result_t          result_next;
  bdc_pkg::result_t          result;
  logic                      out_valid;

  logic                      advance;

  // item moves to the result register when that register is empty or draining
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_time   <= bdc_pkg::DEBOUNCE_TIME_RST;
      long_press_time <= bdc_pkg::LONG_PRESS_TIME_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bdc_pkg::REG_DEBOUNCE_TIME:   debounce_time   <= cfg_data;
        bdc_pkg::REG_LONG_PRESS_TIME: long_press_time <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.func     <= s_tuser;
      in_item.raw_down <= s_tdata[0];
      in_item.now_ms   <= s_tdata[32:1];
    end
  end

  bdc_core u_core (
    .item            (in_item),
    .state           (state),
    .debounce_time   (debounce_time),
    .long_press_time (long_press_time),
    .state_next      (state_next),
    .result          (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bdc_pkg::STATE_RST;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        state <= state_next;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, result};

endmodule

@@ design/bdc_checker.sv @@
// Port-level checks for the button debouncer, bound to the top level.
`timescale 1ns / 1ps

module bdc_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);

  // a stalled result transaction keeps its contents
  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // no result in the first cycle after reset
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_tvalid)
    else $error("result out of reset without input");

  // a click only comes with a release, never with a press
  a_click_release: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2] |-> m_tdata[1] && !m_tdata[0] && !m_tdata[4])
    else $error("click without release");

  // hold time is zero whenever released or on the press itself
  a_hold_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (!m_tdata[4] || m_tdata[0]) |-> m_tdata[36:5] == 32'd0)
    else $error("hold time nonzero while released");

endmodule

bind button_debounce_click_longpress bdc_checker u_bdc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

@@ sim/testbench.sv @@
// Testbench for the button debouncer: directed and random samples against an in-line predictor.
`timescale 1ns / 1ps

// Drives button samples into the stream input and checks every result against a
// predictor of the debouncer state. A short directed run covers the debounce and
// long-press thresholds, clicks, resyncs, wrapping and backward time, and zero
// thresholds. Random phases follow, each with new thresholds (the extremes among
// them): mostly bouncy press/hold/release sequences, plus some noise. Both stream
// sides stall in random bursts, except near the end of the run.

module testbench;

  // Predicts one result per accepted sample and checks results in arrival order
  class debounce_scoreboard;
    logic [bdc_pkg::CFG_W-1:0] settle_ms;
    logic [bdc_pkg::CFG_W-1:0] long_ms;
    bdc_pkg::state_t           st;
    bdc_pkg::result_t          expected_q[$];
    int                        errors;

    function new();
      settle_ms  = bdc_pkg::DEBOUNCE_TIME_RST;
      long_ms    = bdc_pkg::LONG_PRESS_TIME_RST;
      st         = bdc_pkg::STATE_RST;
      errors     = 0;
    endfunction

    function void set_reg(logic idx, logic [bdc_pkg::CFG_W-1:0] val);
      if (idx == bdc_pkg::REG_DEBOUNCE_TIME) begin
        settle_ms = val;
      end else begin
        long_ms = val;
      end
    endfunction

    // Accepted input transaction: advance the predicted state, queue its result
    function void note_sample(bdc_pkg::item_t it);
      bdc_pkg::result_t           r;
      logic [bdc_pkg::TIME_W-1:0] since_change;
      r = '0;
      if (it.func == bdc_pkg::FUNC_RESYNC) begin
        st.raw_level        = it.raw_down;
        st.stable_level     = it.raw_down;
        st.long_fired       = 1'b0;
        st.raw_change_time  = it.now_ms;
        st.press_start_time = it.now_ms;
      end else begin
        if (it.raw_down != st.raw_level) begin
          st.raw_level       = it.raw_down;
          st.raw_change_time = it.now_ms;
        end
        // wrapped difference, compared unsigned
        since_change = it.now_ms - st.raw_change_time;
        if (since_change >= 32'(settle_ms) && st.stable_level != st.raw_level) begin
          st.stable_level = st.raw_level;
          if (st.stable_level) begin
            r.press_event       = 1'b1;
            st.press_start_time = it.now_ms;
            st.long_fired       = 1'b0;
          end else begin
            r.release_event = 1'b1;
            r.click_event   = !st.long_fired;
          end
        end
        if (st.stable_level) begin
          r.hold_ms = it.now_ms - st.press_start_time;
          if (!st.long_fired && r.hold_ms >= 32'(long_ms)) begin
            st.long_fired      = 1'b1;
            r.long_press_event = 1'b1;
          end
        end
      end
      r.down_level = st.stable_level;
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [bdc_pkg::TIME_W-1:0] want,
                                logic [bdc_pkg::TIME_W-1:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    // Accepted output transaction: compare with the oldest prediction
    function void check_result(logic [39:0] data);
      bdc_pkg::result_t got;
      bdc_pkg::result_t want;
      got = data[$bits(bdc_pkg::result_t)-1:0];
      if (expected_q.size() == 0) begin
        $error("result transaction with no sample outstanding: %h", data);
        errors++;
      end else begin
        want = expected_q.pop_front();
        compare_field("press_event", 32'(want.press_event), 32'(got.press_event));
        compare_field("release_event", 32'(want.release_event), 32'(got.release_event));
        compare_field("click_event", 32'(want.click_event), 32'(got.click_event));
        compare_field("long_press_event", 32'(want.long_press_event),
                      32'(got.long_press_event));
        compare_field("down_level", 32'(want.down_level), 32'(got.down_level));
        compare_field("hold_ms", want.hold_ms, got.hold_ms);
      end
    endfunction
  endclass

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      s_tvalid  = 1'b0;
  logic                      s_tready;
  logic [39:0]               s_tdata   = '0;     // raw_down[0], now_ms[32:1], zero pad
  logic                      s_tuser   = bdc_pkg::FUNC_SAMPLE;  // func
  logic                      m_tvalid;
  logic                      m_tready  = 1'b0;
  logic [39:0]               m_tdata;            // press, release, click, long press, down, hold_ms
  logic                      cfg_we    = 1'b0;
  logic                      cfg_index = bdc_pkg::REG_DEBOUNCE_TIME;
  logic [bdc_pkg::CFG_W-1:0] cfg_data  = '0;

  logic                       calm       = 1'b0;  // no stalls on either side once set
  int                         stall_left = 0;
  int                         sent       = 0;     // accepted input transactions
  logic [bdc_pkg::TIME_W-1:0] now_t;              // timestamp of the last sample sent
  logic                       level;              // raw level of the last sample sent
  int unsigned                settle_cfg;         // thresholds in force, used to time samples
  int unsigned                long_cfg;
  debounce_scoreboard         sb;

  button_debounce_click_longpress u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Hard stop, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  // Monitor: both handshakes are sampled at the edge where they complete
  always @(posedge clk) begin
    bdc_pkg::item_t it;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        it.func     = s_tuser;
        it.raw_down = s_tdata[0];
        it.now_ms   = s_tdata[32:1];
        sb.note_sample(it);
      end
      if (m_tvalid && m_tready) begin
        sb.check_result(m_tdata);
      end
    end
  end

  // Receiver back-pressure: random stall bursts
  always @(posedge clk) begin
    if (rst || calm) begin
      m_tready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      m_tready   <= 1'b0;
      stall_left <= $urandom_range(0, 7);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // One input transaction; valid stays high afterwards so back-to-back items need
  // no extra edge. A random gap may come first.
  task automatic send_item(input logic kind, input logic raw,
                           input logic [bdc_pkg::TIME_W-1:0] t);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {7'b0, t, raw};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
    level = raw;
    now_t = t;
  endtask

  task automatic sample(input logic raw, input int unsigned delta);
    send_item(bdc_pkg::FUNC_SAMPLE, raw, now_t + delta);
  endtask

  // Sender pauses until every outstanding result is back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Thresholds change only with nothing in flight
  task automatic set_thresholds(input logic [bdc_pkg::CFG_W-1:0] db,
                                input logic [bdc_pkg::CFG_W-1:0] lp);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= bdc_pkg::REG_DEBOUNCE_TIME;
    cfg_data  <= db;
    @(posedge clk);
    cfg_index <= bdc_pkg::REG_LONG_PRESS_TIME;
    cfg_data  <= lp;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(bdc_pkg::REG_DEBOUNCE_TIME, db);
    sb.set_reg(bdc_pkg::REG_LONG_PRESS_TIME, lp);
    settle_cfg = 32'(db);
    long_cfg   = 32'(lp);
  endtask

  // Contact bounce toward lvl, then a stable sample at the debounce threshold,
  // one just short of it and then one at it, or one at or well past it
  task automatic settle_to(input logic lvl);
    int          bounces;
    int unsigned jitter;
    bounces = $urandom_range(0, 3);
    jitter  = (settle_cfg > 1) ? settle_cfg - 1 : 1;
    repeat (bounces) sample(~level, $urandom_range(0, jitter));
    sample(lvl, $urandom_range(0, jitter));
    case ($urandom_range(0, 2))
      0: sample(lvl, settle_cfg);
      1: begin
        sample(lvl, (settle_cfg == 0) ? 0 : settle_cfg - 1);
        sample(lvl, 1);
      end
      default: sample(lvl, settle_cfg + $urandom_range(0, settle_cfg + 5));
    endcase
  endtask

  // Stable level for a few samples; pressed holds cross the long-press time about half the time
  task automatic hold_for(input logic lvl);
    int          n;
    int unsigned span;
    n    = $urandom_range(1, 5);
    span = lvl ? long_cfg / 2 + 1 : settle_cfg + 2;
    repeat (n) sample(lvl, $urandom_range(0, span));
  endtask

  // Out-of-pattern sample: random level, occasional resync, sometimes a wild time jump
  task automatic noise_item();
    logic                       kind;
    logic [bdc_pkg::TIME_W-1:0] t;
    kind = ($urandom_range(0, 7) == 0) ? bdc_pkg::FUNC_RESYNC : bdc_pkg::FUNC_SAMPLE;
    if ($urandom_range(0, 3) == 0) begin
      t = $urandom;
    end else begin
      t = now_t + $urandom_range(0, 2 * settle_cfg + long_cfg);
    end
    send_item(kind, 1'($urandom_range(0, 1)), t);
  endtask

  initial begin
    logic [bdc_pkg::CFG_W-1:0] db;
    logic [bdc_pkg::CFG_W-1:0] lp;
    int                        phase_end;
    sb         = new();
    now_t      = '0;
    level      = 1'b0;
    settle_cfg = 32'(bdc_pkg::DEBOUNCE_TIME_RST);
    long_cfg   = 32'(bdc_pkg::LONG_PRESS_TIME_RST);
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed, reset thresholds (30 ms debounce, 600 ms long press)
    send_item(bdc_pkg::FUNC_SAMPLE, 1'b0, 32'd0);
    send_item(bdc_pkg::FUNC_SAMPLE, 1'b1, 32'd10);    // raw change starts the settle timer
    send_item(bdc_pkg::FUNC_SAMPLE, 1'b1, 32'd39);    // one ms short of debounce
    send_item(bdc_pkg::FUNC_SAMPLE, 1'b1, 32'd40);    // press exactly at debounce
    send_item(bdc_pkg::FUNC_SAMPLE, 1'b0, 32'd45);    // bounce while held
    send_item(bdc_pkg::FUNC_SAMPLE, 1'b1, 32'd50);
    send_item(bdc_pkg::FUNC_SAMPLE, 1'b1, 32'd640);   // hold exactly at long-press time
    send_item(bdc_pkg::FUNC_SAMPLE, 1'b1, 32'd700);   // no second long press
    send_item(bdc_pkg::FUNC_SAMPLE, 1'b0, 32'd710);
    send_item(bdc_pkg::FUNC_SAMPLE, 1'b0, 32'd740);   // release after long press: no click
    send_item(bdc_pkg::FUNC_SAMPLE, 1'b1, 32'd800);
    send_item(bdc_pkg::FUNC_SAMPLE, 1'b1, 32'd830);
    send_item(bdc_pkg::FUNC_SAMPLE, 1'b0, 32'd900);
    send_item(bdc_pkg::FUNC_SAMPLE, 1'b0, 32'd930);   // short hold: click
    send_item(bdc_pkg::FUNC_RESYNC, 1'b1, 32'hFFFF_FFF0);
    send_item(bdc_pkg::FUNC_SAMPLE, 1'b1, 32'h0000_0100);  // hold wraps past zero
    send_item(bdc_pkg::FUNC_SAMPLE, 1'b1, 32'h0000_0300);
    send_item(bdc_pkg::FUNC_SAMPLE, 1'b0, 32'h0000_0400);
    send_item(bdc_pkg::FUNC_SAMPLE, 1'b0, 32'h0000_03F0);  // time steps backwards
    send_item(bdc_pkg::FUNC_SAMPLE, 1'b0, 32'hFFFF_FFFF);
    send_item(bdc_pkg::FUNC_RESYNC, 1'b0, 32'd0);

    // Zero thresholds: press and long press land on the same item
    set_thresholds('0, '0);
    send_item(bdc_pkg::FUNC_SAMPLE, 1'b1, 32'd5);
    send_item(bdc_pkg::FUNC_SAMPLE, 1'b0, 32'd6);
    send_item(bdc_pkg::FUNC_SAMPLE, 1'b1, 32'd7);
    send_item(bdc_pkg::FUNC_SAMPLE, 1'b1, 32'd8);

    // Random phases, each with its own thresholds and a resync at a random time
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin
          db = 16'($urandom_range(0, 200));
          lp = '0;
        end
        1: begin
          db = '1;
          lp = '1;
        end
        2: begin
          db = 16'd1;
          lp = 16'($urandom_range(1, 50));
        end
        3: begin
          db = 16'($urandom_range(0, 65535));
          lp = 16'($urandom_range(0, 65535));
        end
        4: begin
          db = '0;
          lp = '1;
        end
        5: begin
          db = '1;
          lp = 16'($urandom_range(0, 3000));
        end
        6: begin
          db = '0;
          lp = '0;
        end
        default: begin
          db = 16'($urandom_range(5, 100));
          lp = 16'($urandom_range(100, 2000));
        end
      endcase
      set_thresholds(db, lp);
      send_item(bdc_pkg::FUNC_RESYNC, 1'b0, $urandom);
      phase_end = sent + 130;
      while (sent < phase_end) begin
        // last stretch of the final phase runs without stalls
        if (p == 7 && sent > phase_end - 90) begin
          calm <= 1'b1;
        end
        if ($urandom_range(0, 4) == 0) begin
          noise_item();
        end else begin
          settle_to(1'b1);
          hold_for(1'b1);
          settle_to(1'b0);
          hold_for(1'b0);
        end
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
